// ----- design/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants for the subset sum counter
// Fixed field widths and the one-hot sequencer state type.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int TARGET_BITS  = 10;
	localparam int ELEMENT_BITS = 16;
	localparam int RESULT_BITS  = 32;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SWEEP = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_READ  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

endpackage

// ----- design/ssc_row_mem.sv -----
// ----------------------------------------------------------------------------
// ssc_row_mem: count row storage
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module ssc_row_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_a_addr,
	output logic [DW-1:0] rd_a_data,
	input  logic [AW-1:0] rd_b_addr,
	output logic [DW-1:0] rd_b_data
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_data <= mem_q[rd_a_addr];
		rd_b_data <= mem_q[rd_b_addr];
	end

endmodule

// ----- design/subset_sum_count.sv -----
// ----------------------------------------------------------------------------
// subset_sum_count: counts subsets of a set that add up to a target
// Row-of-counts dynamic program over one shared saturating adder.
// ----------------------------------------------------------------------------
// Usage:
//  - Config: write target_sum with cfg_valid (cfg_ready is always high).
//    Write it only while busy is low and no set is in progress.
//  - Input: one element per beat, taken when start is high and busy low.
//    last_element marks the final element of a set.
//  - Output: on a last element, one result beat: result_valid is high for
//    exactly one cycle with subset_count and count_saturated. The receiver
//    cannot stall; the beat is gone after that cycle.
// Sequencing (t = target clipped to MAX_SUM, v = element value):
//  - Element with v <= t: busy while the sweep writes one row entry per
//    cycle through the dual-read row memory and one adder.
//  - Element with v > t (or zero): no sweep, and busy stays low if not last.
//  - Last element: after any sweep, ST_READ reads the target entry, ST_OUT
//    carries the result beat, then a clearing pass over all MAX_SUM + 1
//    row entries (one row entry per cycle) runs before busy drops.
// Reset: the stored target goes to zero and the same clearing pass runs, so
// busy stays high after arst_n rises until every row entry is cleared.
// ----------------------------------------------------------------------------
module subset_sum_count #(
	parameter int MAX_SUM    = 1023,
	parameter int COUNT_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssc_pkg::TARGET_BITS-1:0]    target_sum,
	// command channel
	input  logic                               start,
	output logic                               busy,
	input  logic [ssc_pkg::ELEMENT_BITS-1:0]   element_value,
	input  logic                               last_element,
	// result channel
	output logic                               result_valid,
	output logic [ssc_pkg::RESULT_BITS-1:0]    subset_count,
	output logic                               count_saturated
);

	localparam int DEPTH = MAX_SUM + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CB    = COUNT_BITS;
	localparam int RB    = ssc_pkg::RESULT_BITS;

	ssc_pkg::state_t state_q, state_d;

	logic [ssc_pkg::TARGET_BITS-1:0] target_q;
	logic [AW-1:0]                   tgt;       // active target, clipped
	logic [AW-1:0]                   j_q;       // sweep index, counts down
	logic [AW-1:0]                   v_q;       // element value in row units
	logic                            last_q;
	logic [AW-1:0]                   clr_q;     // clearing pass address
	logic                            sat_q;     // sticky saturation flag

	// sweep write-back stage
	logic                            upd_s1;
	logic [AW-1:0]                   waddr_s1;

	logic                            accept;
	logic                            do_sweep;

	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [CB-1:0] mem_wr_data;
	logic [AW-1:0] rd_a_addr;
	logic [AW-1:0] rd_b_addr;
	logic [CB-1:0] rd_a_data;
	logic [CB-1:0] rd_b_data;

	logic [CB:0]   sum_w;
	logic          sat_hit;
	logic [CB-1:0] sat_sum;

	// -------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			target_q <= target_sum;
		end
	end

	// target above the row size is clipped to the top entry
	always_comb begin
		if (32'(target_q) > 32'(MAX_SUM)) begin
			tgt = AW'(MAX_SUM);
		end else begin
			tgt = AW'(target_q);
		end
	end

	// -------------------------------------------------------------- command
	assign busy     = (state_q != ssc_pkg::ST_IDLE);
	assign accept   = start && !busy;
	// zero and oversize elements leave the row alone
	assign do_sweep = (element_value != '0) && (32'(element_value) <= 32'(tgt));

	// -------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssc_pkg::ST_CLEAR: begin
				if (clr_q == AW'(MAX_SUM)) begin
					state_d = ssc_pkg::ST_IDLE;
				end
			end
			ssc_pkg::ST_IDLE: begin
				if (accept) begin
					if (do_sweep) begin
						state_d = ssc_pkg::ST_SWEEP;
					end else if (last_element) begin
						state_d = ssc_pkg::ST_READ;
					end
				end
			end
			ssc_pkg::ST_SWEEP: begin
				if (j_q == v_q) begin
					state_d = ssc_pkg::ST_DRAIN;
				end
			end
			ssc_pkg::ST_DRAIN: begin
				state_d = last_q ? ssc_pkg::ST_READ : ssc_pkg::ST_IDLE;
			end
			ssc_pkg::ST_READ: begin
				state_d = ssc_pkg::ST_OUT;
			end
			ssc_pkg::ST_OUT: begin
				state_d = ssc_pkg::ST_CLEAR;
			end
			default: begin
				state_d = ssc_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ssc_pkg::ST_CLEAR;
			clr_q    <= '0;
			j_q      <= '0;
			v_q      <= '0;
			last_q   <= 1'b0;
			upd_s1   <= 1'b0;
			waddr_s1 <= '0;
			sat_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			upd_s1   <= (state_q == ssc_pkg::ST_SWEEP);
			waddr_s1 <= j_q;

			if (state_q == ssc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
				sat_q <= 1'b0;
			end else begin
				clr_q <= '0;
				if (upd_s1 && sat_hit) begin
					sat_q <= 1'b1;
				end
			end

			if (accept) begin
				j_q    <= tgt;
				v_q    <= AW'(element_value);
				last_q <= last_element;
			end else if (state_q == ssc_pkg::ST_SWEEP) begin
				j_q <= j_q - AW'(1);
			end
		end
	end

	// -------------------------------------------------------------- datapath
	// reads of j and j-v never hit an entry already rewritten in this sweep
	assign rd_a_addr = (state_q == ssc_pkg::ST_READ) ? tgt : j_q;
	assign rd_b_addr = j_q - v_q;

	// shared saturating adder
	assign sum_w   = {1'b0, rd_a_data} + {1'b0, rd_b_data};
	assign sat_hit = sum_w[CB] | (&sum_w[CB-1:0]);
	assign sat_sum = sat_hit ? {CB{1'b1}} : sum_w[CB-1:0];

	always_comb begin
		if (state_q == ssc_pkg::ST_CLEAR) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = clr_q;
			mem_wr_data = (clr_q == '0) ? CB'(1) : '0;
		end else begin
			mem_wr_en   = upd_s1;
			mem_wr_addr = waddr_s1;
			mem_wr_data = sat_sum;
		end
	end

	ssc_row_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (CB)
	) u_row (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_a_data (rd_a_data),
		.rd_b_addr (rd_b_addr),
		.rd_b_data (rd_b_data)
	);

	// -------------------------------------------------------------- result
	// target entry read in ST_READ lands in the read register for ST_OUT
	assign result_valid = (state_q == ssc_pkg::ST_OUT);

	generate
		if (CB > RB) begin : g_wide
			logic over;
			assign over            = |rd_a_data[CB-1:RB];
			assign subset_count    = over ? {RB{1'b1}} : rd_a_data[RB-1:0];
			assign count_saturated = sat_q | over;
		end else begin : g_narrow
			assign subset_count    = RB'(rd_a_data);
			assign count_saturated = sat_q;
		end
	endgenerate

endmodule
